@@ rtl/gcr_pkg.sv @@
package gcr_pkg;

    // glyph geometry and character range
    localparam int unsigned GLYPH_COLS = 5;
    localparam int unsigned GLYPH_ROWS = 7;
    localparam int unsigned FONT_ENTRIES = 95;

    localparam logic [7:0] FIRST_CODE    = 8'd32;
    localparam logic [7:0] LAST_CODE     = 8'd126;
    localparam logic [7:0] FALLBACK_CODE = 8'd63;  // question mark

    localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);
    localparam logic [2:0] LAST_ROW = 3'(GLYPH_ROWS - 1);

    // screen registers
    localparam logic [10:0] SCREEN_LIMIT      = 11'd1024;
    localparam logic [10:0] SCREEN_RESET      = 11'd240;
    localparam logic [1:0]  REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0]  REG_SCREEN_HEIGHT = 2'd1;

    // signed pixel position, wide enough that origin plus offsets never wraps
    typedef logic signed [17:0] pos_t;
    typedef logic [7:0]         font_col_t;

    // five column bytes per glyph, bit r of a column is row r
    localparam font_col_t FONT_ROM [FONT_ENTRIES][GLYPH_COLS] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00},'{8'h00,8'h00,8'h5F,8'h00,8'h00},
        '{8'h00,8'h07,8'h00,8'h07,8'h00},'{8'h14,8'h7F,8'h14,8'h7F,8'h14},
        '{8'h24,8'h2A,8'h7F,8'h2A,8'h12},'{8'h23,8'h13,8'h08,8'h64,8'h62},
        '{8'h36,8'h49,8'h55,8'h22,8'h50},'{8'h00,8'h05,8'h03,8'h00,8'h00},
        '{8'h00,8'h1C,8'h22,8'h41,8'h00},'{8'h00,8'h41,8'h22,8'h1C,8'h00},
        '{8'h14,8'h08,8'h3E,8'h08,8'h14},'{8'h08,8'h08,8'h3E,8'h08,8'h08},
        '{8'h00,8'h50,8'h30,8'h00,8'h00},'{8'h08,8'h08,8'h08,8'h08,8'h08},
        '{8'h00,8'h60,8'h60,8'h00,8'h00},'{8'h20,8'h10,8'h08,8'h04,8'h02},
        '{8'h3E,8'h51,8'h49,8'h45,8'h3E},'{8'h00,8'h42,8'h7F,8'h40,8'h00},
        '{8'h42,8'h61,8'h51,8'h49,8'h46},'{8'h21,8'h41,8'h45,8'h4B,8'h31},
        '{8'h18,8'h14,8'h12,8'h7F,8'h10},'{8'h27,8'h45,8'h45,8'h45,8'h39},
        '{8'h3C,8'h4A,8'h49,8'h49,8'h30},'{8'h01,8'h71,8'h09,8'h05,8'h03},
        '{8'h36,8'h49,8'h49,8'h49,8'h36},'{8'h06,8'h49,8'h49,8'h29,8'h1E},
        '{8'h00,8'h36,8'h36,8'h00,8'h00},'{8'h00,8'h56,8'h36,8'h00,8'h00},
        '{8'h08,8'h14,8'h22,8'h41,8'h00},'{8'h14,8'h14,8'h14,8'h14,8'h14},
        '{8'h00,8'h41,8'h22,8'h14,8'h08},'{8'h02,8'h01,8'h51,8'h09,8'h06},
        '{8'h32,8'h49,8'h79,8'h41,8'h3E},'{8'h7E,8'h11,8'h11,8'h11,8'h7E},
        '{8'h7F,8'h49,8'h49,8'h49,8'h36},'{8'h3E,8'h41,8'h41,8'h41,8'h22},
        '{8'h7F,8'h41,8'h41,8'h22,8'h1C},'{8'h7F,8'h49,8'h49,8'h49,8'h41},
        '{8'h7F,8'h09,8'h09,8'h09,8'h01},'{8'h3E,8'h41,8'h49,8'h49,8'h7A},
        '{8'h7F,8'h08,8'h08,8'h08,8'h7F},'{8'h00,8'h41,8'h7F,8'h41,8'h00},
        '{8'h20,8'h40,8'h41,8'h3F,8'h01},'{8'h7F,8'h08,8'h14,8'h22,8'h41},
        '{8'h7F,8'h40,8'h40,8'h40,8'h40},'{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
        '{8'h7F,8'h04,8'h08,8'h10,8'h7F},'{8'h3E,8'h41,8'h41,8'h41,8'h3E},
        '{8'h7F,8'h09,8'h09,8'h09,8'h06},'{8'h3E,8'h41,8'h51,8'h21,8'h5E},
        '{8'h7F,8'h09,8'h19,8'h29,8'h46},'{8'h46,8'h49,8'h49,8'h49,8'h31},
        '{8'h01,8'h01,8'h7F,8'h01,8'h01},'{8'h3F,8'h40,8'h40,8'h40,8'h3F},
        '{8'h1F,8'h20,8'h40,8'h20,8'h1F},'{8'h3F,8'h40,8'h38,8'h40,8'h3F},
        '{8'h63,8'h14,8'h08,8'h14,8'h63},'{8'h07,8'h08,8'h70,8'h08,8'h07},
        '{8'h61,8'h51,8'h49,8'h45,8'h43},'{8'h00,8'h7F,8'h41,8'h41,8'h00},
        '{8'h02,8'h04,8'h08,8'h10,8'h20},'{8'h00,8'h41,8'h41,8'h7F,8'h00},
        '{8'h04,8'h02,8'h01,8'h02,8'h04},'{8'h40,8'h40,8'h40,8'h40,8'h40},
        '{8'h00,8'h01,8'h02,8'h04,8'h00},'{8'h20,8'h54,8'h54,8'h54,8'h78},
        '{8'h7F,8'h48,8'h44,8'h44,8'h38},'{8'h38,8'h44,8'h44,8'h44,8'h20},
        '{8'h38,8'h44,8'h44,8'h48,8'h7F},'{8'h38,8'h54,8'h54,8'h54,8'h18},
        '{8'h08,8'h7E,8'h09,8'h01,8'h02},'{8'h0C,8'h52,8'h52,8'h52,8'h3E},
        '{8'h7F,8'h08,8'h04,8'h04,8'h78},'{8'h00,8'h44,8'h7D,8'h40,8'h00},
        '{8'h20,8'h40,8'h44,8'h3D,8'h00},'{8'h7F,8'h10,8'h28,8'h44,8'h00},
        '{8'h00,8'h41,8'h7F,8'h40,8'h00},'{8'h7C,8'h04,8'h18,8'h04,8'h78},
        '{8'h7C,8'h08,8'h04,8'h04,8'h78},'{8'h38,8'h44,8'h44,8'h44,8'h38},
        '{8'h7C,8'h14,8'h14,8'h14,8'h08},'{8'h08,8'h14,8'h14,8'h18,8'h7C},
        '{8'h7C,8'h08,8'h04,8'h04,8'h08},'{8'h48,8'h54,8'h54,8'h54,8'h20},
        '{8'h04,8'h3F,8'h44,8'h40,8'h20},'{8'h3C,8'h40,8'h40,8'h20,8'h7C},
        '{8'h1C,8'h20,8'h40,8'h20,8'h1C},'{8'h3C,8'h40,8'h30,8'h40,8'h3C},
        '{8'h44,8'h28,8'h10,8'h28,8'h44},'{8'h0C,8'h50,8'h50,8'h50,8'h3C},
        '{8'h44,8'h64,8'h54,8'h4C,8'h44},'{8'h00,8'h08,8'h36,8'h41,8'h00},
        '{8'h00,8'h00,8'h7F,8'h00,8'h00},'{8'h00,8'h41,8'h36,8'h08,8'h00},
        '{8'h10,8'h08,8'h08,8'h10,8'h08}
    };

endpackage

@@ rtl/gcr_clip.sv @@
module gcr_clip (
    input  logic           aclk,
    input  logic           adv,
    input  gcr_pkg::pos_t  start,
    input  logic [7:0]     scale,
    input  logic [10:0]    limit,
    output logic [9:0]     first,
    output logic [7:0]     len
);

    gcr_pkg::pos_t lo_reg, lo_next;
    gcr_pkg::pos_t hi_reg, hi_next;
    gcr_pkg::pos_t hi_sum;
    gcr_pkg::pos_t span;
    logic [9:0]    first_reg, first_next;
    logic [7:0]    len_reg, len_next;

    // span ends: left edge clamped at zero, right edge clamped at the screen
    always_comb begin
        hi_sum  = start + gcr_pkg::pos_t'({10'b0, scale});
        lo_next = start[17] ? '0 : start;
        if (hi_sum > gcr_pkg::pos_t'({7'b0, limit})) begin
            hi_next = gcr_pkg::pos_t'({7'b0, limit});
        end else begin
            hi_next = hi_sum;
        end
    end

    // visible length, empty when the span closes up
    always_comb begin
        span = hi_reg - lo_reg;
        if (hi_reg > lo_reg) begin
            first_next = lo_reg[9:0];
            len_next   = span[7:0];
        end else begin
            first_next = '0;
            len_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            first_reg <= first_next;
            len_reg   <= len_next;
        end
    end

    assign first = first_reg;
    assign len   = len_reg;

endmodule

@@ rtl/glyph_cell_rasterizer_core.sv @@
// 5x7 character generator: each accepted character beat yields 35 cell beats
// in column-major order, one per cycle while m_ready stays high, issued by the
// cell sequencer. The next character is taken in the cycle its predecessor
// issues its final cell. A cell reaches the result channel through the offset
// and font stage, two clipping stages and the output register. Screen size
// registers may only be written while no character is in flight; values above
// 1024 act as 1024.
module glyph_cell_rasterizer_core (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [10:0]        cfg_wdata,
    // character request
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_origin_x,
    input  logic signed [15:0] s_origin_y,
    input  logic [7:0]         s_char_code,
    input  logic [15:0]        s_fg_color,
    input  logic [15:0]        s_bg_color,
    input  logic [7:0]         s_scale,
    // cell results
    output logic               m_valid,
    input  logic               m_ready,
    output logic [9:0]         m_cell_x,
    output logic [9:0]         m_cell_y,
    output logic [7:0]         m_cell_width,
    output logic [7:0]         m_cell_height,
    output logic [15:0]        m_cell_color,
    output logic               m_last_cell
);

    logic [10:0] screen_width_reg, screen_height_reg;
    logic [10:0] width_lim, height_lim;

    logic              busy_reg, busy_next;
    logic [2:0]        col_reg, col_next;
    logic [2:0]        row_reg, row_next;
    logic signed [15:0] req_ox_reg, req_oy_reg;
    logic [6:0]        req_glyph_reg;
    logic [15:0]       req_fg_reg, req_bg_reg;
    logic [7:0]        req_scale_reg;

    logic        adv;
    logic        s_beat;
    logic        seq_last;
    logic        issue;
    logic [7:0]  eff_code;
    logic [10:0] col_off, row_off;
    gcr_pkg::font_col_t glyph_col;

    // stage 0 to 2 pipeline registers
    logic          v0_reg, v1_reg, v2_reg;
    gcr_pkg::pos_t sx_reg, sy_reg;
    logic [7:0]    s0_scale_reg;
    logic [15:0]   c0_reg, c1_reg, c2_reg;
    logic          l0_reg, l1_reg, l2_reg;

    logic [9:0]  first_x, first_y;
    logic [7:0]  len_x, len_y;
    logic        empty;

    logic        m_valid_reg;
    logic [9:0]  m_cell_x_reg, m_cell_y_reg;
    logic [7:0]  m_cell_width_reg, m_cell_height_reg;
    logic [15:0] m_cell_color_reg;
    logic        m_last_cell_reg;

    // screen size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= gcr_pkg::SCREEN_RESET;
            screen_height_reg <= gcr_pkg::SCREEN_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_addr == gcr_pkg::REG_SCREEN_WIDTH) begin
                screen_width_reg <= cfg_wdata;
            end else if (cfg_addr == gcr_pkg::REG_SCREEN_HEIGHT) begin
                screen_height_reg <= cfg_wdata;
            end
        end
    end

    assign width_lim  = (screen_width_reg > gcr_pkg::SCREEN_LIMIT) ?
                        gcr_pkg::SCREEN_LIMIT : screen_width_reg;
    assign height_lim = (screen_height_reg > gcr_pkg::SCREEN_LIMIT) ?
                        gcr_pkg::SCREEN_LIMIT : screen_height_reg;

    // whole pipeline moves when the output register can take a cell
    assign adv      = !m_valid_reg || m_ready;
    assign seq_last = (col_reg == gcr_pkg::LAST_COL) && (row_reg == gcr_pkg::LAST_ROW);
    assign issue    = busy_reg && adv;
    assign s_ready  = !busy_reg || (adv && seq_last);
    assign s_beat   = s_valid && s_ready;

    // out-of-range codes fall back to the question mark glyph
    assign eff_code = (s_char_code < gcr_pkg::FIRST_CODE || s_char_code > gcr_pkg::LAST_CODE) ?
                      gcr_pkg::FALLBACK_CODE : s_char_code;

    // cell sequencer
    always_comb begin
        busy_next = busy_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (s_beat) begin
            busy_next = 1'b1;
            col_next  = '0;
            row_next  = '0;
        end else if (issue) begin
            if (seq_last) begin
                busy_next = 1'b0;
                col_next  = '0;
                row_next  = '0;
            end else if (row_reg == gcr_pkg::LAST_ROW) begin
                row_next = '0;
                col_next = col_reg + 3'd1;
            end else begin
                row_next = row_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            col_reg  <= '0;
            row_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

    // request holding registers
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            req_ox_reg    <= s_origin_x;
            req_oy_reg    <= s_origin_y;
            req_glyph_reg <= 7'(eff_code - gcr_pkg::FIRST_CODE);
            req_fg_reg    <= s_fg_color;
            req_bg_reg    <= s_bg_color;
            req_scale_reg <= s_scale;
        end
    end

    // stage 0: cell offsets and font lookup
    assign col_off   = 11'(col_reg) * 11'(req_scale_reg);
    assign row_off   = 11'(row_reg) * 11'(req_scale_reg);
    assign glyph_col = gcr_pkg::FONT_ROM[req_glyph_reg][col_reg];

    always_ff @(posedge aclk) begin
        if (adv) begin
            sx_reg       <= gcr_pkg::pos_t'({{2{req_ox_reg[15]}}, req_ox_reg})
                            + gcr_pkg::pos_t'({7'b0, col_off});
            sy_reg       <= gcr_pkg::pos_t'({{2{req_oy_reg[15]}}, req_oy_reg})
                            + gcr_pkg::pos_t'({7'b0, row_off});
            s0_scale_reg <= req_scale_reg;
            c0_reg       <= glyph_col[row_reg] ? req_fg_reg : req_bg_reg;
            l0_reg       <= seq_last;
            c1_reg       <= c0_reg;
            l1_reg       <= l0_reg;
            c2_reg       <= c1_reg;
            l2_reg       <= l1_reg;
        end
    end

    // valid bits travel with the cells
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // stages 1 and 2: clipping per axis
    gcr_clip u_clip_x (
        .aclk  (aclk),
        .adv   (adv),
        .start (sx_reg),
        .scale (s0_scale_reg),
        .limit (width_lim),
        .first (first_x),
        .len   (len_x)
    );

    gcr_clip u_clip_y (
        .aclk  (aclk),
        .adv   (adv),
        .start (sy_reg),
        .scale (s0_scale_reg),
        .limit (height_lim),
        .first (first_y),
        .len   (len_y)
    );

    // output register: a cell empty on either axis is empty on both
    assign empty = (len_x == 8'd0) || (len_y == 8'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_cell_x_reg      <= empty ? 10'd0 : first_x;
            m_cell_y_reg      <= empty ? 10'd0 : first_y;
            m_cell_width_reg  <= empty ? 8'd0 : len_x;
            m_cell_height_reg <= empty ? 8'd0 : len_y;
            m_cell_color_reg  <= c2_reg;
            m_last_cell_reg   <= l2_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_cell_x      = m_cell_x_reg;
    assign m_cell_y      = m_cell_y_reg;
    assign m_cell_width  = m_cell_width_reg;
    assign m_cell_height = m_cell_height_reg;
    assign m_cell_color  = m_cell_color_reg;
    assign m_last_cell   = m_last_cell_reg;

endmodule

@@ rtl/gcr_checker.sv @@
module gcr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [9:0]  m_cell_x,
    input logic [9:0]  m_cell_y,
    input logic [7:0]  m_cell_width,
    input logic [7:0]  m_cell_height,
    input logic [15:0] m_cell_color,
    input logic        m_last_cell
);

    logic [5:0] cell_cnt_reg, cell_cnt_next;
    logic       m_beat;

    assign m_beat = m_valid && m_ready;

    // count cell beats within the current glyph
    always_comb begin
        cell_cnt_next = cell_cnt_reg;
        if (m_beat) begin
            if (m_last_cell) begin
                cell_cnt_next = '0;
            end else begin
                cell_cnt_next = cell_cnt_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_cnt_reg <= '0;
        end else begin
            cell_cnt_reg <= cell_cnt_next;
        end
    end

    // stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_x) && $stable(m_cell_y)
            && $stable(m_cell_width) && $stable(m_cell_height)
            && $stable(m_cell_color) && $stable(m_last_cell))
        else $error("result beat changed while stalled");

    // last flag marks exactly the 35th cell of a glyph
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_cell == (cell_cnt_reg == 6'd34)))
        else $error("last cell flag out of step with cell count");

    // an empty cell is empty in every coordinate
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_cell_width == 8'd0 || m_cell_height == 8'd0) |->
            m_cell_x == 10'd0 && m_cell_y == 10'd0
            && m_cell_width == 8'd0 && m_cell_height == 8'd0)
        else $error("empty cell carries a position or size");

    // a drawn cell stays inside the addressable screen
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cell_width != 8'd0 |->
            (11'(m_cell_x) + 11'(m_cell_width) <= 11'd1024)
            && (11'(m_cell_y) + 11'(m_cell_height) <= 11'd1024))
        else $error("cell runs past the screen limit");

endmodule

bind glyph_cell_rasterizer_core gcr_checker u_gcr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_cell_x      (m_cell_x),
    .m_cell_y      (m_cell_y),
    .m_cell_width  (m_cell_width),
    .m_cell_height (m_cell_height),
    .m_cell_color  (m_cell_color),
    .m_last_cell   (m_last_cell)
);

@@ bench/glyph_cell_checker.sv @@
`timescale 1ns / 1ps

module glyph_cell_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [10:0]        cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_origin_x,
    input  logic signed [15:0] s_origin_y,
    input  logic [7:0]         s_char_code,
    input  logic [15:0]        s_fg_color,
    input  logic [15:0]        s_bg_color,
    input  logic [7:0]         s_scale,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [9:0]         m_cell_x,
    input  logic [9:0]         m_cell_y,
    input  logic [7:0]         m_cell_width,
    input  logic [7:0]         m_cell_height,
    input  logic [15:0]        m_cell_color,
    input  logic               m_last_cell,
    output int                 fail_count,
    output int                 cells_pending
);

    localparam int FIRST_PRINTABLE = 32;
    localparam int LAST_PRINTABLE  = 126;
    localparam int QUESTION_MARK   = 63;
    localparam int COLS            = 5;
    localparam int ROWS            = 7;
    localparam int SCREEN_MAX      = 1024;
    localparam logic [10:0] SCREEN_AT_RESET = 11'd240;

    typedef struct packed {
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [7:0]  code;
        logic [15:0] fg;
        logic [15:0] bg;
        logic [7:0]  scale;
    } char_req_t;

    typedef struct packed {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [7:0]  width;
        logic [7:0]  height;
        logic [15:0] color;
        logic        last;
    } cell_t;

    // printable glyphs from space upwards, column 0 in the top byte
    localparam logic [39:0] GLYPHS [95] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h1008081008
    };

    logic [10:0] screen_w = SCREEN_AT_RESET;
    logic [10:0] screen_h = SCREEN_AT_RESET;
    cell_t       expected_cells [$];

    // visible part of [start, start+len) on [0, limit)
    function automatic int clip_span(input int start, input int len, input int limit,
                                     output int first);
        int lo;
        int hi;
        lo = (start < 0) ? 0 : start;
        hi = start + len;
        if (hi > limit) hi = limit;
        if (hi <= lo) begin
            first = 0;
            return 0;
        end
        first = lo;
        return hi - lo;
    endfunction

    function automatic cell_t predict_cell(input char_req_t ch, input int col, input int row,
                                           input int sw, input int sh);
        cell_t       c;
        int          idx;
        int          cx;
        int          cy;
        int          w;
        int          h;
        int          side;
        logic [39:0] glyph;
        logic [7:0]  bits;
        idx = int'(ch.code);
        if (idx < FIRST_PRINTABLE || idx > LAST_PRINTABLE) idx = QUESTION_MARK;
        glyph = GLYPHS[idx - FIRST_PRINTABLE];
        bits  = glyph[39 - 8 * col -: 8];
        side  = int'(ch.scale);
        cx = 0;
        cy = 0;
        w  = 0;
        h  = 0;
        if (side != 0) begin
            w = clip_span(int'($signed(ch.origin_x)) + col * side, side, sw, cx);
            h = clip_span(int'($signed(ch.origin_y)) + row * side, side, sh, cy);
            if (w == 0 || h == 0) begin
                cx = 0;
                cy = 0;
                w  = 0;
                h  = 0;
            end
        end
        c.x      = 10'(cx);
        c.y      = 10'(cy);
        c.width  = 8'(w);
        c.height = 8'(h);
        c.color  = bits[row] ? ch.fg : ch.bg;
        c.last   = (col == COLS - 1) && (row == ROWS - 1);
        return c;
    endfunction

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d got %0d", $time, field, want, got);
        end
    endtask

    // mirror the registers, predict on input beats, compare on result beats
    always @(posedge aclk) begin : watch
        char_req_t req;
        cell_t     want;
        int        sw;
        int        sh;
        if (!aresetn) begin
            screen_w <= SCREEN_AT_RESET;
            screen_h <= SCREEN_AT_RESET;
            expected_cells.delete();
            cells_pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == gcr_pkg::REG_SCREEN_WIDTH) screen_w <= cfg_wdata;
                else if (cfg_addr == gcr_pkg::REG_SCREEN_HEIGHT) screen_h <= cfg_wdata;
            end
            if (m_valid && m_ready) begin
                if (expected_cells.size() == 0) begin
                    fail_count++;
                    $display("%0t: cell beat with nothing expected, got x=%0d y=%0d",
                             $time, m_cell_x, m_cell_y);
                end else begin
                    want = expected_cells.pop_front();
                    compare_field("cell_x", 16'(want.x), 16'(m_cell_x));
                    compare_field("cell_y", 16'(want.y), 16'(m_cell_y));
                    compare_field("cell_width", 16'(want.width), 16'(m_cell_width));
                    compare_field("cell_height", 16'(want.height), 16'(m_cell_height));
                    compare_field("cell_color", want.color, m_cell_color);
                    compare_field("last_cell", 16'(want.last), 16'(m_last_cell));
                end
            end
            if (s_valid && s_ready) begin
                req = '{s_origin_x, s_origin_y, s_char_code, s_fg_color, s_bg_color, s_scale};
                sw = (int'(screen_w) > SCREEN_MAX) ? SCREEN_MAX : int'(screen_w);
                sh = (int'(screen_h) > SCREEN_MAX) ? SCREEN_MAX : int'(screen_h);
                for (int col = 0; col < COLS; col++)
                    for (int row = 0; row < ROWS; row++)
                        expected_cells.push_back(predict_cell(req, col, row, sw, sh));
            end
            cells_pending <= expected_cells.size();
        end
    end

endmodule

@@ bench/glyph_cell_rasterizer_core_tb.sv @@
`timescale 1ns / 1ps

module glyph_cell_rasterizer_core_tb;

    localparam logic [1:0] REG_SPARE_LO     = 2'd2;
    localparam logic [1:0] REG_SPARE_HI     = 2'd3;
    localparam int         LONG_HOLD_CYCLES = 300;
    localparam int         SETTLE_CYCLES    = 12;

    logic               aclk;
    logic               aresetn       = 1'b0;
    logic               cfg_wr_en     = 1'b0;
    logic [1:0]         cfg_addr      = gcr_pkg::REG_SCREEN_WIDTH;
    logic [10:0]        cfg_wdata     = '0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_origin_x    = '0;
    logic signed [15:0] s_origin_y    = '0;
    logic [7:0]         s_char_code   = '0;
    logic [15:0]        s_fg_color    = '0;
    logic [15:0]        s_bg_color    = '0;
    logic [7:0]         s_scale       = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [9:0]         m_cell_x;
    logic [9:0]         m_cell_y;
    logic [7:0]         m_cell_width;
    logic [7:0]         m_cell_height;
    logic [15:0]        m_cell_color;
    logic               m_last_cell;
    int                 fail_count;
    int                 cells_pending;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic long_hold      = 1'b0;
    int   held_cycles    = 0;
    int   visible_w      = 240;
    int   visible_h      = 240;

    glyph_cell_rasterizer_core uut (.*);
    glyph_cell_checker checker_i (.*);

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // result side: random stalls, plus one long hold-off counted here
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (long_hold && held_cycles < LONG_HOLD_CYCLES) begin
            m_ready     <= 1'b0;
            held_cycles <= held_cycles + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_char(input logic signed [15:0] ox, input logic signed [15:0] oy,
                             input logic [7:0] code, input logic [15:0] fg,
                             input logic [15:0] bg, input logic [7:0] side);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid     <= 1'b1;
        s_origin_x  <= ox;
        s_origin_y  <= oy;
        s_char_code <= code;
        s_fg_color  <= fg;
        s_bg_color  <= bg;
        s_scale     <= side;
        do @(posedge aclk); while (!s_ready);
    endtask

    // origin near either edge of the screen, anywhere on it, or anywhere at all
    function automatic int place(input int extent, input int span);
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) return int'($urandom_range(0, 2 * span + 8)) - span - 4;
        if (pick < 60) return extent - int'($urandom_range(0, span + 4));
        if (pick < 85) return int'($urandom_range(0, 1100));
        return int'($signed(16'($urandom())));
    endfunction

    task automatic send_random_char();
        int         pick;
        int         side;
        int         ox;
        int         oy;
        logic [7:0] code;
        pick = $urandom_range(99);
        if (pick < 5) side = 0;
        else if (pick < 80) side = $urandom_range(1, 24);
        else if (pick < 93) side = $urandom_range(25, 90);
        else side = $urandom_range(91, 255);
        ox = place(visible_w, side * 5);
        oy = place(visible_h, side * 7);
        code = ($urandom_range(99) < 85) ? 8'($urandom_range(32, 126)) : 8'($urandom());
        send_char(16'(ox), 16'(oy), code, 16'($urandom()), 16'($urandom()), 8'(side));
    endtask

    // hold the sender until every cell has come back and the pipeline is empty
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (cells_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // both screen registers, then a write to an unused index that must be ignored
    task automatic program_screen(input int w, input int h);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= gcr_pkg::REG_SCREEN_WIDTH;
        cfg_wdata <= 11'(w);
        @(posedge aclk);
        cfg_addr  <= gcr_pkg::REG_SCREEN_HEIGHT;
        cfg_wdata <= 11'(h);
        @(posedge aclk);
        cfg_addr  <= ($urandom_range(1) != 0) ? REG_SPARE_HI : REG_SPARE_LO;
        cfg_wdata <= 11'($urandom());
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        visible_w = (w > int'(gcr_pkg::SCREEN_LIMIT)) ? int'(gcr_pkg::SCREEN_LIMIT) : w;
        visible_h = (h > int'(gcr_pkg::SCREEN_LIMIT)) ? int'(gcr_pkg::SCREEN_LIMIT) : h;
    endtask

    task automatic run_random(input int w, input int h, input int idle_pct,
                              input int stall_pct, input int count);
        wait_idle();
        program_screen(w, h);
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        repeat (count) send_random_char();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed characters on the reset screen of 240 by 240
        send_char(16'sd0, 16'sd0, 8'h41, 16'hFFFF, 16'h0000, 8'd1);
        send_char(16'sd10, 16'sd20, 8'h20, 16'h1234, 16'hABCD, 8'd2);
        send_char(16'sd30, 16'sd20, 8'h7E, 16'hF800, 16'h07E0, 8'd3);
        // codes either side of the printable range fall back to question mark
        send_char(16'sd50, 16'sd20, 8'h00, 16'h001F, 16'hFFE0, 8'd2);
        send_char(16'sd70, 16'sd20, 8'h1F, 16'h001F, 16'hFFE0, 8'd2);
        send_char(16'sd90, 16'sd20, 8'h7F, 16'h001F, 16'hFFE0, 8'd2);
        send_char(16'sd110, 16'sd20, 8'hFF, 16'h001F, 16'hFFE0, 8'd2);
        send_char(16'sd130, 16'sd20, 8'h3F, 16'h001F, 16'hFFE0, 8'd2);
        // zero scale empties every cell
        send_char(16'sd5, 16'sd5, 8'h57, 16'hFFFF, 16'h0000, 8'd0);
        // full scale clipped on the right and bottom
        send_char(16'sd0, 16'sd0, 8'h4D, 16'h0000, 16'hFFFF, 8'd255);
        // origins at the extremes, wholly off screen
        send_char(16'sh8000, 16'sh8000, 8'h4D, 16'hFFFF, 16'h0000, 8'd255);
        send_char(16'sh7FFF, 16'sh7FFF, 8'h4D, 16'hFFFF, 16'h0000, 8'd255);
        // left and top clipping
        send_char(-16'sd3, -16'sd5, 8'h23, 16'hAAAA, 16'h5555, 8'd4);
        send_char(-16'sd1, -16'sd1, 8'h40, 16'h5555, 16'hAAAA, 8'd1);
        send_char(-16'sd1, -16'sd1, 8'h80, 16'h0000, 16'hFFFF, 8'd255);
        send_char(-16'sd600, 16'sd100, 8'h48, 16'hFFFF, 16'h0000, 8'd8);
        // right and bottom edges
        send_char(16'sd238, 16'sd236, 8'h57, 16'h7BEF, 16'h8410, 8'd3);
        send_char(16'sd100, 16'sd239, 8'h5F, 16'hFFFF, 16'h0000, 8'd1);
        send_char(16'sd200, 16'sd200, 8'h2A, 16'hAAAA, 16'h5555, 8'd9);

        // random phases over a range of screen sizes and idling patterns
        run_random(1024, 1024, 0, 0, 40);
        run_random(1, 1, 54, 0, 30);
        run_random(2047, 1500, 0, 54, 40);
        run_random(0, 1023, 30, 30, 20);
        run_random(320, 200, 30, 30, 40);

        // long receiver hold-off while the sender keeps offering beats
        wait_idle();
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        long_hold <= 1'b1;
        repeat (10) send_random_char();

        run_random(1023, 1, 0, 54, 40);
        run_random(100, 1024, 0, 0, 30);

        wait_idle();
        if (fail_count == 0)
            $display("[glyph_cell_rasterizer_core] OK");
        else
            $display("[glyph_cell_rasterizer_core] ERROR");
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("[glyph_cell_rasterizer_core] ERROR");
        $finish;
    end

endmodule
